### src/overload_queue_admission_top_defines.svh
// Assertion macros for the top module, which checks its own logic.
`ifndef OVERLOAD_QUEUE_ADMISSION_TOP_DEFINES_SVH
`define OVERLOAD_QUEUE_ADMISSION_TOP_DEFINES_SVH
// Checks that an implication holds at every clock edge outside reset.
`define OQA_ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");
// Checks that a consequence holds at the clock edge after the antecedent.
`define OQA_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### src/oqa_pkg.sv
`default_nettype none
package oqa_pkg;
	localparam int QueueDepth = 16;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = 7;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_ASK = 2'd1;
	localparam logic [1:0] OP_DONE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] POL_BLOCK = 2'd0;
	localparam logic [1:0] POL_TAIL = 2'd1;
	localparam logic [1:0] POL_RANDOM = 2'd2;
	localparam logic [1:0] POL_HEAD = 2'd3;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_SEED = 2'd2;

	localparam logic [2:0] K_ADMIT = 3'd0;
	localparam logic [2:0] K_REFUSE = 3'd1;
	localparam logic [2:0] K_EVICT = 3'd2;
	localparam logic [2:0] K_DISPATCH = 3'd3;
	localparam logic [2:0] K_HELD = 3'd4;
	localparam logic [2:0] K_NOWORK = 3'd5;
	localparam logic [2:0] K_DONE = 3'd6;

	typedef struct packed {
		logic [1:0] opcode;
		logic [15:0] tag;
		logic [31:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [15:0] tag_res;
		logic [31:0] wait_time;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] arrival;
	} entry_t;

	// Command from the controller to the row of cells.
	typedef struct packed {
		logic push;
		logic remove;
		logic [IdxW-1:0] idx;
		entry_t data;
	} cell_cmd_t;
endpackage
`default_nettype wire

### src/oqa_cell.sv
`default_nettype none
module oqa_cell
	import oqa_pkg::*;
(
	input wire logic clk,
	input wire cell_cmd_t cmd,
	input wire logic [IdxW-1:0] my_idx,
	input wire logic [IdxW:0] count,
	input wire entry_t from_next,
	output entry_t entry
);
	entry_t entry_q;

	// On a removal every cell at or above the index takes its neighbour's entry.
	always_ff @(posedge clk) begin
		if (cmd.remove && (my_idx >= cmd.idx)) begin
			entry_q <= from_next;
		end else if (cmd.push && ({1'b0, my_idx} == count)) begin
			entry_q <= cmd.data;
		end
	end

	assign entry = entry_q;
endmodule
`default_nettype wire

### src/overload_queue_admission_top.sv
`default_nettype none
// Admission controller for a bounded request queue held in a row of cells
// that shift towards the head on each removal. The queue holds 16 entries.
// An item normally passes through acceptance, a pending-arrival check and a
// main step before the next acceptance; a completion with no pending arrival
// to admit, or an unused opcode, ends after the check, and a drop-head
// overload adds a final step that admits the arrival. A random-drop overload
// adds, for each eviction, a step that reduces the generator value modulo the
// fill count one bit at a time and a step that removes the entry, with up to
// five evictions for a full queue. A result that waits for the output
// register to be taken holds the item in its current step.
module overload_queue_admission_top
	import oqa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	`include "overload_queue_admission_top_defines.svh"

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE = 6'b000010,
		ST_MAIN = 6'b000100,
		ST_MOD = 6'b001000,
		ST_EVICT = 6'b010000,
		ST_FINAL = 6'b100000
	} state_t;

	state_t state_q;
	logic [1:0] policy_q;
	logic [6:0] capacity_q;
	logic [15:0] lfsr_q;
	logic [IdxW:0] count_q;
	logic [CntW-1:0] in_service_q;
	logic held_valid_q;
	entry_t held_q;
	in_item_t item_q;
	logic [2:0] evict_left_q;
	logic out_valid_q;
	out_item_t out_q;
	logic [15:0] mod_val_q;
	logic [IdxW:0] mod_rem_q;
	logic [3:0] mod_cnt_q;

	cell_cmd_t cmd;
	entry_t cells [QueueDepth];
	entry_t nexts [QueueDepth];

	for (genvar g = 0; g < QueueDepth; g++) begin : g_row
		if (g == QueueDepth - 1) begin : g_end
			assign nexts[g] = cells[g];
		end else begin : g_mid
			assign nexts[g] = cells[g + 1];
		end
		oqa_cell u_cell (
			.clk(clk),
			.cmd(cmd),
			.my_idx(IdxW'(g)),
			.count(count_q),
			.from_next(nexts[g]),
			.entry(cells[g])
		);
	end

	logic full;
	logic full_done;
	logic [7:0] occ;
	logic [7:0] occ_done;
	logic out_free;
	logic [15:0] lfsr_nx;
	logic [IdxW:0] mod_shift;
	logic [IdxW:0] mod_step;
	logic [7:0] evict_num;
	logic [15:0] evict_prod;
	logic [3:0] n_evict;
	logic emit;
	out_item_t res;
	state_t state_nx;
	logic [1:0] op;

	assign op = item_q.opcode;
	assign occ = 8'(count_q) + 8'(in_service_q);
	assign full = (occ >= {1'b0, capacity_q}) || (count_q == (IdxW+1)'(QueueDepth));
	// Occupancy as it will be once a completion has left service.
	assign occ_done = occ - 8'(in_service_q != '0);
	assign full_done = (occ_done >= {1'b0, capacity_q})
		|| (count_q == (IdxW+1)'(QueueDepth));
	assign out_free = !out_valid_q || !out_stall;
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ 16'hB400) : (lfsr_q >> 1);
	// Restoring remainder step: one generator bit per cycle, most significant first.
	assign mod_shift = {mod_rem_q[IdxW-1:0], mod_val_q[15]};
	assign mod_step = (mod_shift >= count_q) ? (mod_shift - count_q) : mod_shift;
	// Eviction count ceil(0.3 * queued) as (3 * queued + 9) / 10, using 205 / 2048.
	assign evict_num = 8'(count_q) * 8'd3 + 8'd9;
	assign evict_prod = 16'(evict_num) * 16'd205;
	assign n_evict = evict_prod[14:11];

	always_comb begin
		cmd = '0;
		cmd.data = held_q;
		emit = 1'b0;
		res = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_PRE;
				end
			end
			ST_PRE: begin
				if (out_free) begin
					state_nx = ST_MAIN;
					if (op == OP_DONE) begin
						emit = 1'b1;
						res.kind = K_DONE;
						if (!held_valid_q || full_done) begin
							state_nx = ST_IDLE;
						end
					end else begin
						if (held_valid_q && !full) begin
							emit = 1'b1;
							res.kind = K_ADMIT;
							res.tag_res = held_q.tag;
							cmd.push = 1'b1;
						end
						if (op != OP_ARRIVE && op != OP_ASK) begin
							state_nx = ST_IDLE;
						end
					end
				end
			end
			ST_MAIN: begin
				if (out_free) begin
					state_nx = ST_IDLE;
					priority case (op)
						OP_DONE: begin
							if (held_valid_q && !full) begin
								emit = 1'b1;
								res.kind = K_ADMIT;
								res.tag_res = held_q.tag;
								cmd.push = 1'b1;
							end
						end
						OP_ASK: begin
							emit = 1'b1;
							if (count_q == '0) begin
								res.kind = K_NOWORK;
							end else begin
								res.kind = K_DISPATCH;
								res.tag_res = cells[0].tag;
								res.wait_time = item_q.timestamp - cells[0].arrival;
								cmd.remove = 1'b1;
							end
						end
						OP_ARRIVE: begin
							emit = 1'b1;
							res.tag_res = item_q.tag;
							cmd.data.tag = item_q.tag;
							cmd.data.arrival = item_q.timestamp;
							if (held_valid_q) begin
								res.kind = K_REFUSE;
							end else if (!full) begin
								res.kind = K_ADMIT;
								cmd.push = 1'b1;
							end else if (policy_q == POL_BLOCK) begin
								res.kind = K_HELD;
							end else if (policy_q == POL_TAIL || count_q == '0) begin
								res.kind = K_REFUSE;
							end else if (policy_q == POL_HEAD) begin
								res.kind = K_EVICT;
								res.tag_res = cells[0].tag;
								cmd.remove = 1'b1;
								state_nx = ST_FINAL;
							end else begin
								emit = 1'b0;
								state_nx = ST_MOD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == 4'd15) begin
					state_nx = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (out_free) begin
					emit = 1'b1;
					res.kind = K_EVICT;
					res.tag_res = cells[mod_rem_q[IdxW-1:0]].tag;
					cmd.remove = 1'b1;
					cmd.idx = mod_rem_q[IdxW-1:0];
					if (evict_left_q == 3'd1 || count_q == (IdxW+1)'(1)) begin
						state_nx = ST_FINAL;
					end else begin
						state_nx = ST_MOD;
					end
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					emit = 1'b1;
					res.kind = K_ADMIT;
					res.tag_res = item_q.tag;
					cmd.push = 1'b1;
					cmd.data.tag = item_q.tag;
					cmd.data.arrival = item_q.timestamp;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
		res.last = (state_nx == ST_IDLE);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_BLOCK;
			capacity_q <= 7'd16;
			lfsr_q <= 16'd1;
			count_q <= '0;
			in_service_q <= '0;
			held_valid_q <= 1'b0;
			evict_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POLICY: policy_q <= cfg_data[1:0];
					REG_CAPACITY: capacity_q <= cfg_data[6:0];
					REG_SEED: lfsr_q <= (cfg_data == '0) ? 16'd1 : cfg_data;
					default: begin
					end
				endcase
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.remove) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == ST_PRE && out_free && op == OP_DONE && in_service_q != '0) begin
				in_service_q <= in_service_q - 1'b1;
			end
			if (state_q == ST_MAIN && out_free && op == OP_ASK && count_q != '0
				&& in_service_q != 7'd127) begin
				in_service_q <= in_service_q + 1'b1;
			end
			if (cmd.push && cmd.data == held_q && res.kind == K_ADMIT
				&& res.tag_res == held_q.tag && (state_q == ST_PRE || op == OP_DONE)) begin
				held_valid_q <= 1'b0;
			end
			if (state_q == ST_MAIN && out_free && op == OP_ARRIVE && res.kind == K_HELD) begin
				held_valid_q <= 1'b1;
			end
			if (state_q == ST_MAIN && state_nx == ST_MOD) begin
				evict_left_q <= n_evict[2:0];
			end
			// The generator advances once for each random eviction.
			if (state_nx == ST_MOD && state_q != ST_MOD) begin
				lfsr_q <= lfsr_nx;
			end
			if (state_q == ST_EVICT && out_free) begin
				evict_left_q <= evict_left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (emit) begin
			out_q <= res;
		end
		if (state_q == ST_MAIN && out_free && op == OP_ARRIVE && res.kind == K_HELD) begin
			held_q.tag <= item_q.tag;
			held_q.arrival <= item_q.timestamp;
		end
		if (state_nx == ST_MOD && state_q != ST_MOD) begin
			mod_val_q <= lfsr_nx;
			mod_rem_q <= '0;
			mod_cnt_q <= '0;
		end else if (state_q == ST_MOD) begin
			mod_val_q <= mod_val_q << 1;
			mod_rem_q <= mod_step;
			mod_cnt_q <= mod_cnt_q + 1'b1;
		end
	end

	`OQA_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= (IdxW+1)'(QueueDepth))
	`OQA_ASSERT_IMPL(a_no_overwrite, clk, arst_n, out_valid_q && out_stall, !emit)
	`OQA_ASSERT_NEXT(a_take_busy, clk, arst_n, in_valid && !in_stall, state_q == ST_PRE)
endmodule
`default_nettype wire

### tb/overload_queue_admission_top_test.sv
`default_nettype none
module overload_queue_admission_top_test;
	import oqa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_POLICY;
	logic [15:0] cfg_data = '0;

	overload_queue_admission_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the admission state.
	logic [1:0] sh_policy = POL_BLOCK;
	int unsigned sh_capacity = 16;
	logic [15:0] sh_lfsr = 16'd1;
	logic [15:0] sh_tags[QueueDepth];
	logic [31:0] sh_arrivals[QueueDepth];
	int unsigned sh_queued = 0;
	int unsigned sh_busy = 0;
	bit sh_held = 1'b0;
	logic [15:0] sh_held_tag = '0;
	logic [31:0] sh_held_arrival = '0;

	in_item_t request_q[$];
	out_item_t outcome_q[$];
	bit failed = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_cycle = 0;
	int unsigned quiet_cycles = 0;
	logic [31:0] clock_ticks;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit queue_full();
		return (sh_queued + sh_busy) >= sh_capacity || sh_queued >= QueueDepth;
	endfunction

	function automatic void note(logic [2:0] kind, logic [15:0] tag, logic [31:0] waited);
		out_item_t r;
		r.kind = kind;
		r.tag_res = tag;
		r.wait_time = waited;
		r.last = 1'b0;
		outcome_q.push_back(r);
	endfunction

	function automatic void append(logic [15:0] tag, logic [31:0] ts);
		if (sh_queued < QueueDepth) begin
			sh_tags[sh_queued] = tag;
			sh_arrivals[sh_queued] = ts;
			sh_queued++;
		end
	endfunction

	function automatic void evict(int unsigned idx);
		note(K_EVICT, sh_tags[idx], '0);
		for (int unsigned i = idx; i + 1 < sh_queued; i++) begin
			sh_tags[i] = sh_tags[i + 1];
			sh_arrivals[i] = sh_arrivals[i + 1];
		end
		sh_queued--;
	endfunction

	function automatic void release_held();
		if (sh_held && !queue_full()) begin
			append(sh_held_tag, sh_held_arrival);
			note(K_ADMIT, sh_held_tag, '0);
			sh_held = 1'b0;
		end
	endfunction

	function automatic void handle_arrival(logic [15:0] tag, logic [31:0] ts);
		int unsigned n;
		if (sh_held) begin
			note(K_REFUSE, tag, '0);
			return;
		end
		if (!queue_full()) begin
			append(tag, ts);
			note(K_ADMIT, tag, '0);
			return;
		end
		if (sh_policy == POL_BLOCK) begin
			sh_held = 1'b1;
			sh_held_tag = tag;
			sh_held_arrival = ts;
			note(K_HELD, tag, '0);
			return;
		end
		if (sh_policy == POL_TAIL || sh_queued == 0) begin
			note(K_REFUSE, tag, '0);
			return;
		end
		if (sh_policy == POL_RANDOM) begin
			n = (3 * sh_queued + 9) / 10;
			for (int unsigned k = 0; k < n && sh_queued > 0; k++) begin
				sh_lfsr = sh_lfsr[0] ? ((sh_lfsr >> 1) ^ 16'hB400) : (sh_lfsr >> 1);
				evict(sh_lfsr % sh_queued);
			end
		end else begin
			evict(0);
		end
		append(tag, ts);
		note(K_ADMIT, tag, '0);
	endfunction

	function automatic void predict_outcomes(in_item_t it);
		int unsigned before_n;
		before_n = outcome_q.size();
		if (it.opcode == OP_DONE) begin
			if (sh_busy > 0)
				sh_busy--;
			note(K_DONE, '0, '0);
			release_held();
		end else begin
			release_held();
			if (it.opcode == OP_ARRIVE) begin
				handle_arrival(it.tag, it.timestamp);
			end else if (it.opcode == OP_ASK) begin
				if (sh_queued == 0) begin
					note(K_NOWORK, '0, '0);
				end else begin
					note(K_DISPATCH, sh_tags[0], it.timestamp - sh_arrivals[0]);
					for (int unsigned i = 0; i + 1 < sh_queued; i++) begin
						sh_tags[i] = sh_tags[i + 1];
						sh_arrivals[i] = sh_arrivals[i + 1];
					end
					sh_queued--;
					if (sh_busy < 127)
						sh_busy++;
				end
			end
		end
		if (outcome_q.size() > before_n)
			outcome_q[outcome_q.size() - 1].last = 1'b1;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_outcomes(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data <= request_q.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Receiver: checks each result and stalls on a pattern that changes mode.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					$error("unexpected result: kind %0d tag %0h", out_data.kind, out_data.tag_res);
					failed = 1'b1;
				end else begin
					if (out_data.kind !== outcome_q[0].kind) begin
						$error("kind: expected %0d, got %0d", outcome_q[0].kind, out_data.kind);
						failed = 1'b1;
					end
					if (out_data.tag_res !== outcome_q[0].tag_res) begin
						$error("tag_res: expected %0h, got %0h",
							outcome_q[0].tag_res, out_data.tag_res);
						failed = 1'b1;
					end
					if (out_data.wait_time !== outcome_q[0].wait_time) begin
						$error("wait_time: expected %0h, got %0h",
							outcome_q[0].wait_time, out_data.wait_time);
						failed = 1'b1;
					end
					if (out_data.last !== outcome_q[0].last) begin
						$error("last: expected %0d, got %0d", outcome_q[0].last, out_data.last);
						failed = 1'b1;
					end
					void'(outcome_q.pop_front());
				end
			end
			stall_cycle++;
			if (stall_cycle % 80 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 8);
				default: out_stall <= (stall_cycle % 7 < 2);
			endcase
		end
	end

	// Watchdog on cycles in which neither side moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 5000) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POLICY)
			sh_policy = value[1:0];
		else if (idx == REG_CAPACITY)
			sh_capacity = value[6:0];
		else if (idx == REG_SEED)
			sh_lfsr = (value == 0) ? 16'd1 : value;
	endtask

	task automatic configure(logic [1:0] pol, logic [15:0] cap, logic [15:0] seed);
		write_reg(REG_POLICY, 16'(pol));
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_SEED, seed);
	endtask

	task automatic queue_request(logic [1:0] op, logic [15:0] tag, logic [31:0] ts);
		in_item_t it;
		it.opcode = op;
		it.tag = tag;
		it.timestamp = ts;
		request_q.push_back(it);
	endtask

	// Arrivals dominate so that the queue fills and the overload policy acts.
	task automatic queue_random(int unsigned count);
		int unsigned pick;
		logic [1:0] op;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 55) ? OP_ARRIVE : (pick < 78) ? OP_ASK
				: (pick < 96) ? OP_DONE : OP_UNUSED;
			clock_ticks += $urandom_range(0, 40);
			queue_request(op, 16'($urandom),
				($urandom_range(0, 19) == 0) ? $urandom : clock_ticks);
		end
	endtask

	// Lets every queued transaction drain before the registers are touched.
	task automatic drain();
		do
			@(posedge clk);
		while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		clock_ticks = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		configure(POL_BLOCK, 16'd2, 16'd1);
		queue_request(OP_ASK, 16'h0000, 32'h0);
		queue_request(OP_DONE, 16'hFFFF, 32'hFFFF_FFFF);
		queue_request(OP_ARRIVE, 16'h0000, 32'hFFFF_FFFF);
		queue_request(OP_ARRIVE, 16'hFFFF, 32'h0000_0005);
		queue_request(OP_ARRIVE, 16'h1234, 32'h0000_0010);
		queue_request(OP_ARRIVE, 16'h5678, 32'h0000_0011);
		queue_request(OP_ASK, 16'h0, 32'h0000_0003);
		queue_request(OP_DONE, 16'h0, 32'h0);
		queue_request(OP_UNUSED, 16'hAAAA, 32'h5555_5555);
		queue_request(OP_ASK, 16'h0, 32'hFFFF_FFFF);
		queue_request(OP_ASK, 16'h0, 32'h0000_0020);
		queue_request(OP_ASK, 16'h0, 32'h0000_0021);
		drain();

		configure(POL_TAIL, 16'd1, 16'hFFFF);
		queue_request(OP_ARRIVE, 16'h0001, 32'h1);
		queue_request(OP_ARRIVE, 16'h0002, 32'h2);
		queue_request(OP_ASK, 16'h0, 32'h3);
		queue_request(OP_ARRIVE, 16'h0003, 32'h4);
		drain();

		configure(POL_HEAD, 16'd1, 16'h0000);
		queue_request(OP_ARRIVE, 16'h0011, 32'h1);
		queue_request(OP_ARRIVE, 16'h0012, 32'h2);
		queue_request(OP_ASK, 16'h0, 32'h3);
		queue_request(OP_ARRIVE, 16'h0013, 32'h4);
		queue_request(OP_DONE, 16'h0, 32'h5);
		drain();

		configure(POL_RANDOM, 16'd64, 16'hACE1);
		for (int i = 0; i < 18; i++)
			queue_request(OP_ARRIVE, 16'($urandom), 32'h100 + i);
		queue_request(OP_DONE, 16'h0, 32'h0);
		drain();

		configure(POL_RANDOM, 16'd16, 16'($urandom_range(1, 65535)));
		queue_random(60);
		drain();
		configure(POL_BLOCK, 16'd64, 16'($urandom_range(1, 65535)));
		queue_random(60);
		drain();
		configure(POL_HEAD, 16'd8, 16'($urandom_range(1, 65535)));
		queue_random(60);
		drain();
		configure(POL_TAIL, 16'd4, 16'($urandom_range(1, 65535)));
		queue_random(50);
		drain();
		for (int p = 0; p < 4; p++) begin
			configure(2'($urandom_range(0, 3)), 16'($urandom_range(1, 64)),
				16'($urandom_range(1, 65535)));
			queue_random(50);
			drain();
		end

		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
